### hdl/mva_pkg.sv
// Shared types, constants and codes of the mesh vertex normal accumulator.
// No dependencies; every other file of the block imports this package.
package mva_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = 11;
  localparam int POS_W        = 16;
  localparam int CORNER_W     = 16;
  localparam int NORM_W       = 20;
  localparam int ACC_W        = 24;
  localparam int ACC_ENT_W    = 3 * ACC_W + 1;
  localparam int CROSS_W      = 35;
  localparam int MAG_W        = 31;
  localparam int SUM_W        = 64;
  localparam int LEN_W        = 32;
  localparam int QUOT_W       = 18;
  localparam int DIVN_W       = 46;
  localparam int MUL_W        = 33;
  localparam int SCALE_W      = 16;
  localparam int FRAC_W       = 14;
  localparam int STEP_W       = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDING      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

  localparam logic [1:0] CORNER_ORDER [2][3] = '{'{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}};

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_FACE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [VIDX_W-1:0]       vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [CORNER_W-1:0]     corner_a;
    logic [CORNER_W-1:0]     corner_b;
    logic [CORNER_W-1:0]     corner_c;
    logic                    face_active;
  } req_t;

  typedef struct packed {
    logic                     result_kind;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic                     degenerate;
    logic                     face_skipped;
    logic                     vertex_used;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLEAR, OP_PREAD, OP_PLATCH, OP_XMUL, OP_XACC, OP_AREAD, OP_ALATCH,
    OP_MAG, OP_SQMUL, OP_SQACC, OP_SQGO, OP_DEGEN, OP_SCMUL, OP_DIVGO, OP_NSTORE,
    OP_AWRITE, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
    logic              take;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       sqrt_done;
    logic       len_zero;
    logic       div_done;
    logic       out_free;
    logic [1:0] in_type;
    logic       in_active;
    logic       cur_face;
    logic [2:0] corner_ok;
  } ctrl_sts_t;

  typedef enum logic [18:0] {
    S_CLEAR   = 19'h00001,
    S_IDLE    = 19'h00002,
    S_PREAD   = 19'h00004,
    S_PLATCH  = 19'h00008,
    S_XMUL    = 19'h00010,
    S_XACC    = 19'h00020,
    S_RDREAD  = 19'h00040,
    S_RDLATCH = 19'h00080,
    S_MAG     = 19'h00100,
    S_SQMUL   = 19'h00200,
    S_SQACC   = 19'h00400,
    S_SQGO    = 19'h00800,
    S_SQWAIT  = 19'h01000,
    S_SCMUL   = 19'h02000,
    S_DIVGO   = 19'h04000,
    S_DIVWAIT = 19'h08000,
    S_ACRD    = 19'h10000,
    S_ACWR    = 19'h20000,
    S_EMIT    = 19'h40000
  } state_t;

endpackage

### hdl/mva_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on mva_pkg for widths.
module mva_sqrt import mva_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] radicand,
  output logic             done,
  output logic [LEN_W-1:0] root
);

  localparam int STEPS = SUM_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [SUM_W-1:0] x;
  logic [SUM_W-1:0] r;
  logic [SUM_W-1:0] bitv;
  logic [SUM_W-1:0] trial;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign trial = r + bitv;
  assign root  = r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= radicand;
      r    <= '0;
      bitv <= SUM_W'(1) << (SUM_W - 2);
    end else if (busy) begin
      if (x >= trial) begin
        x <= x - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

### hdl/mva_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on mva_pkg for widths.
module mva_div import mva_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int DSH_W = LEN_W + QUOT_W - 1;
  localparam int CNT_W = $clog2(QUOT_W);

  logic [DIVN_W-1:0] rem;
  logic [DSH_W-1:0]  dsh;
  logic [DSH_W-1:0]  rem_ext;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              fits;

  assign rem_ext = DSH_W'(rem);
  assign fits    = rem_ext >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsh  <= {divisor, {(QUOT_W-1){1'b0}}};
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVN_W'(rem_ext - dsh);
      end
      quot <= {quot[QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

endmodule

### hdl/mva_dp.sv
// Datapath: configuration, position and accumulator memories, shared multiplier,
// root and divide units, result register. Depends on mva_pkg, mva_sqrt, mva_div.
module mva_dp import mva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp
);

  logic [VCNT_W-1:0]       vertex_count;
  logic                    winding_swap;
  logic [SCALE_W-1:0]      normal_scale;
  logic [VIDX_W-1:0]       clr_cnt;
  req_t                    req_r;

  logic [3*POS_W-1:0]      pos_mem [MAX_VERTICES];
  logic [3*POS_W-1:0]      pos_rd;
  logic [ACC_ENT_W-1:0]    acc_mem [MAX_VERTICES];
  logic [ACC_ENT_W-1:0]    acc_rd;
  logic                    acc_we;
  logic [VIDX_W-1:0]       acc_wa;
  logic [VIDX_W-1:0]       acc_ra;
  logic [ACC_ENT_W-1:0]    acc_wd;

  logic signed [POS_W-1:0]   p [3][3];
  logic signed [POS_W:0]     da [3];
  logic signed [POS_W:0]     db [3];
  logic signed [CROSS_W-1:0] vec [3];
  logic [CROSS_W-1:0]        mag_v [3];
  logic [CROSS_W-1:0]        mag_max;
  logic [1:0]                shamt;
  logic [MAG_W-1:0]          u [3];
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] prod;
  logic [SUM_W-1:0]          sum;
  logic signed [NORM_W-1:0]  n [3];
  logic                      deg_r;
  logic                      skip_r;
  logic                      used_r;

  logic [CORNER_W-1:0]       corner [3];
  logic [VCNT_W-1:0]         limit;
  logic [2:0]                ok;
  logic [1:0]                k;
  logic [CORNER_W-1:0]       corner_sel;
  logic                      ok_sel;
  logic [MAG_W-1:0]          u_sel;
  logic                      neg_sel;
  logic                      is_read;

  logic                      sqrt_done;
  logic [LEN_W-1:0]          len;
  logic                      div_done;
  logic [QUOT_W-1:0]         quot;
  logic [DIVN_W-1:0]         dividend;

  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] a, logic [NORM_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W+1-NORM_W){b[NORM_W-1]}}, b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  assign k       = cmd.step[1:0];
  assign is_read = req_r.req_type == REQ_READ;

  always_comb begin
    corner[0] = req_r.corner_a;
    corner[1] = req_r.corner_b;
    corner[2] = req_r.corner_c;
    limit = (vertex_count > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vertex_count;
    for (int i = 0; i < 3; i++) begin
      ok[i] = corner[i] < CORNER_W'(limit);
    end
    unique case (k)
      2'd0:    begin corner_sel = corner[0]; ok_sel = ok[0]; u_sel = u[0]; end
      2'd1:    begin corner_sel = corner[1]; ok_sel = ok[1]; u_sel = u[1]; end
      default: begin corner_sel = corner[2]; ok_sel = ok[2]; u_sel = u[2]; end
    endcase
    unique case (k)
      2'd0:    neg_sel = vec[0][CROSS_W-1];
      2'd1:    neg_sel = vec[1][CROSS_W-1];
      default: neg_sel = vec[2][CROSS_W-1];
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da[i] = (POS_W+1)'(p[CORNER_ORDER[winding_swap][1]][i])
            - (POS_W+1)'(p[CORNER_ORDER[winding_swap][0]][i]);
      db[i] = (POS_W+1)'(p[CORNER_ORDER[winding_swap][2]][i])
            - (POS_W+1)'(p[CORNER_ORDER[winding_swap][0]][i]);
      mag_v[i] = vec[i][CROSS_W-1] ? CROSS_W'(-vec[i]) : CROSS_W'(vec[i]);
    end
    mag_max = mag_v[0];
    if (mag_v[1] > mag_max) mag_max = mag_v[1];
    if (mag_v[2] > mag_max) mag_max = mag_v[2];
    priority if (mag_max[MAG_W+2]) shamt = 2'd3;
    else if (mag_max[MAG_W+1])     shamt = 2'd2;
    else if (mag_max[MAG_W])       shamt = 2'd1;
    else                           shamt = 2'd0;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_XMUL: begin
        unique case (cmd.step)
          3'd0:    begin mul_a = MUL_W'(da[1]); mul_b = MUL_W'(db[2]); end
          3'd1:    begin mul_a = MUL_W'(da[2]); mul_b = MUL_W'(db[1]); end
          3'd2:    begin mul_a = MUL_W'(da[2]); mul_b = MUL_W'(db[0]); end
          3'd3:    begin mul_a = MUL_W'(da[0]); mul_b = MUL_W'(db[2]); end
          3'd4:    begin mul_a = MUL_W'(da[0]); mul_b = MUL_W'(db[1]); end
          default: begin mul_a = MUL_W'(da[1]); mul_b = MUL_W'(db[0]); end
        endcase
      end
      OP_SQMUL: begin
        mul_a = signed'(MUL_W'(u_sel));
        mul_b = signed'(MUL_W'(u_sel));
      end
      OP_SCMUL: begin
        mul_a = signed'(MUL_W'(u_sel));
        mul_b = signed'(MUL_W'(normal_scale));
      end
      default: ;
    endcase
  end

  always_comb begin
    if (is_read) begin
      dividend = {prod[DIVN_W-3:0], 2'b00} + DIVN_W'(len >> 1);
    end else begin
      dividend = DIVN_W'({u_sel, {FRAC_W{1'b0}}}) + DIVN_W'(len >> 1);
    end
  end

  always_comb begin
    acc_ra = is_read ? req_r.vertex_index : corner_sel[VIDX_W-1:0];
    acc_we = 1'b0;
    acc_wa = clr_cnt;
    acc_wd = '0;
    priority if (cmd.op == OP_CLEAR) begin
      acc_we = 1'b1;
    end else if (cmd.take && req.req_type == REQ_LOAD) begin
      acc_we = 1'b1;
      acc_wa = req.vertex_index;
    end else if (cmd.op == OP_AWRITE) begin
      acc_we = 1'b1;
      acc_wa = corner_sel[VIDX_W-1:0];
      acc_wd = {sat_add(acc_rd[ACC_ENT_W-1 -: ACC_W], n[0]),
                sat_add(acc_rd[2*ACC_W -: ACC_W], n[1]),
                sat_add(acc_rd[ACC_W -: ACC_W], n[2]), 1'b1};
    end else begin
      acc_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && req.req_type == REQ_LOAD) begin
      pos_mem[req.vertex_index] <= {req.pos_x, req.pos_y, req.pos_z};
    end
    pos_rd <= pos_mem[corner_sel[VIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_rd <= acc_mem[acc_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      winding_swap <= 1'b0;
      normal_scale <= SCALE_RESET;
      clr_cnt      <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VERTEX_COUNT: vertex_count <= cfg_data[VCNT_W-1:0];
          CFG_WINDING:      winding_swap <= cfg_data[0];
          CFG_SCALE:        normal_scale <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.op == OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r  <= req;
      deg_r  <= 1'b0;
      used_r <= 1'b0;
      skip_r <= (req.req_type == REQ_FACE) && !req.face_active;
      for (int i = 0; i < 3; i++) begin
        n[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        OP_PLATCH: begin
          p[k][0] <= ok_sel ? pos_rd[3*POS_W-1 -: POS_W] : '0;
          p[k][1] <= ok_sel ? pos_rd[2*POS_W-1 -: POS_W] : '0;
          p[k][2] <= ok_sel ? pos_rd[POS_W-1:0] : '0;
        end
        OP_XMUL, OP_SQMUL, OP_SCMUL: begin
          prod <= mul_a * mul_b;
        end
        OP_XACC: begin
          if (!cmd.step[0]) begin
            vec[cmd.step[2:1]] <= prod[CROSS_W-1:0];
          end else begin
            vec[cmd.step[2:1]] <= vec[cmd.step[2:1]] - prod[CROSS_W-1:0];
          end
        end
        OP_ALATCH: begin
          vec[0] <= CROSS_W'(signed'(acc_rd[ACC_ENT_W-1 -: ACC_W]));
          vec[1] <= CROSS_W'(signed'(acc_rd[2*ACC_W -: ACC_W]));
          vec[2] <= CROSS_W'(signed'(acc_rd[ACC_W -: ACC_W]));
          used_r <= acc_rd[0];
        end
        OP_MAG: begin
          for (int i = 0; i < 3; i++) begin
            u[i] <= MAG_W'(mag_v[i] >> shamt);
          end
        end
        OP_SQACC: begin
          sum <= ((cmd.step == '0) ? '0 : sum) + SUM_W'(prod);
        end
        OP_DEGEN: begin
          deg_r <= 1'b1;
        end
        OP_NSTORE: begin
          n[k] <= neg_sel ? -signed'(NORM_W'(quot)) : signed'(NORM_W'(quot));
        end
        OP_EMIT: begin
          rsp.result_kind  <= is_read;
          rsp.norm_x       <= n[0];
          rsp.norm_y       <= n[1];
          rsp.norm_z       <= n[2];
          rsp.degenerate   <= deg_r;
          rsp.face_skipped <= skip_r;
          rsp.vertex_used  <= is_read & used_r;
        end
        default: ;
      endcase
    end
  end

  mva_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_SQGO),
    .radicand (sum),
    .done     (sqrt_done),
    .root     (len)
  );

  mva_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIVGO),
    .dividend (dividend),
    .divisor  (len),
    .done     (div_done),
    .quot     (quot)
  );

  always_comb begin
    sts.clr_last  = clr_cnt == {VIDX_W{1'b1}};
    sts.sqrt_done = sqrt_done;
    sts.len_zero  = len == '0;
    sts.div_done  = div_done;
    sts.out_free  = !rsp_valid || !rsp_stall;
    sts.in_type   = req.req_type;
    sts.in_active = req.face_active;
    sts.cur_face  = req_r.req_type == REQ_FACE;
    sts.corner_ok = ok;
  end

endmodule

### hdl/mva_ctrl.sv
// Controller state machine: sequences the datapath one request at a time.
// Depends on mva_pkg for command, status and state types.
module mva_ctrl import mva_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd.op     = OP_NOP;
    cmd.step   = step;
    cmd.take   = 1'b0;
    req_stall  = state != S_IDLE;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.take  = 1'b1;
          step_next = '0;
          unique case (sts.in_type)
            REQ_FACE: state_next = sts.in_active ? S_PREAD : S_EMIT;
            REQ_READ: state_next = S_RDREAD;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_PREAD: begin
        cmd.op     = OP_PREAD;
        state_next = S_PLATCH;
      end
      S_PLATCH: begin
        cmd.op = OP_PLATCH;
        if (step == STEP_W'(2)) begin
          step_next  = '0;
          state_next = S_XMUL;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_PREAD;
        end
      end
      S_XMUL: begin
        cmd.op     = OP_XMUL;
        state_next = S_XACC;
      end
      S_XACC: begin
        cmd.op = OP_XACC;
        if (step == STEP_W'(5)) begin
          step_next  = '0;
          state_next = S_MAG;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_XMUL;
        end
      end
      S_RDREAD: begin
        cmd.op     = OP_AREAD;
        state_next = S_RDLATCH;
      end
      S_RDLATCH: begin
        cmd.op     = OP_ALATCH;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.op     = OP_MAG;
        step_next  = '0;
        state_next = S_SQMUL;
      end
      S_SQMUL: begin
        cmd.op     = OP_SQMUL;
        state_next = S_SQACC;
      end
      S_SQACC: begin
        cmd.op = OP_SQACC;
        if (step == STEP_W'(2)) begin
          step_next  = '0;
          state_next = S_SQGO;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_SQMUL;
        end
      end
      S_SQGO: begin
        cmd.op     = OP_SQGO;
        state_next = S_SQWAIT;
      end
      S_SQWAIT: begin
        if (sts.sqrt_done) begin
          step_next = '0;
          if (sts.len_zero) begin
            cmd.op     = OP_DEGEN;
            state_next = sts.cur_face ? S_ACRD : S_EMIT;
          end else begin
            state_next = sts.cur_face ? S_DIVGO : S_SCMUL;
          end
        end
      end
      S_SCMUL: begin
        cmd.op     = OP_SCMUL;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.op     = OP_DIVGO;
        state_next = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (sts.div_done) begin
          cmd.op = OP_NSTORE;
          if (step == STEP_W'(2)) begin
            step_next  = '0;
            state_next = sts.cur_face ? S_ACRD : S_EMIT;
          end else begin
            step_next  = step + 1'b1;
            state_next = sts.cur_face ? S_DIVGO : S_SCMUL;
          end
        end
      end
      S_ACRD: begin
        if (sts.corner_ok[step[1:0]]) begin
          cmd.op     = OP_AREAD;
          state_next = S_ACWR;
        end else if (step == STEP_W'(2)) begin
          state_next = S_EMIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_ACWR: begin
        cmd.op = OP_AWRITE;
        if (step == STEP_W'(2)) begin
          state_next = S_EMIT;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_ACRD;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/mesh_vertex_normal_accumulator.sv
// Top level of the mesh vertex normal accumulator.
// Depends on mva_pkg, mva_ctrl and mva_dp.
//
// Keeps up to 1024 vertex positions (Q8.8) and one saturating normal
// accumulator per vertex. A load request stores a position and clears that
// vertex's accumulator as it is taken, with no result. A face request forms
// the unit cross product of its corners in Q1.14, returns it and adds it to
// each in-range corner's accumulator; an inactive face returns at once with
// face_skipped set. A read request returns the normalized accumulator scaled
// by normal_scale. After reset each accumulator entry is cleared in turn
// while req_stall stays high; configuration writes are taken during that
// time. One request is in work at a time: a face or read runs the 32-step
// square root and, unless degenerate, three 18-step divisions on the shared
// divider; a finished result waits in the output register while the next
// request is taken.
module mesh_vertex_normal_accumulator import mva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mva_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
